FILE: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define PSQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("psq assertion failed");

// consequent must hold in the cycle after the antecedent
`define PSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psq sequence assertion failed");

`endif

FILE: sv/psq_pkg.sv
// shared types, constants and microcode rom of the priority scheduler queue
// no dependencies
`timescale 1ns / 1ps

package psq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W      = 3;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_SERVE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [15:0] process_id;
    logic [15:0] burst_length;
    logic [7:0]  job_priority;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_id;
    logic [7:0]  served_priority;
    logic [31:0] waiting_time;
    logic [31:0] turnaround_time;
    logic [31:0] total_waiting;
    logic [31:0] total_turnaround;
    logic [4:0]  queue_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [7:0]  prio;
  } job_t;

  typedef struct packed {
    logic insert;
    logic serve;
  } store_cmd_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } store_stat_t;

  // datapath action of one step
  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_LATCH,
    UOP_INSERT,
    UOP_SERVE,
    UOP_SUMS,
    UOP_EMIT
  } uop_t;

  // how the step counter moves on
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_DISPATCH,
    JC_FAULT,
    JC_OUT_FREE
  } jcond_t;

  typedef struct packed {
    uop_t              uop;
    jcond_t            jc;
    logic [STEP_W-1:0] target;
  } ctl_t;

  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_INS  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SRV0 = 3'd2;  // must follow STEP_INS for dispatch
  localparam logic [STEP_W-1:0] STEP_SRV1 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd4;

  function automatic ctl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctl_t w;
    unique case (step)
      STEP_IDLE: w = '{uop: UOP_LATCH,  jc: JC_DISPATCH, target: STEP_INS};
      STEP_INS:  w = '{uop: UOP_INSERT, jc: JC_GOTO,     target: STEP_EMIT};
      STEP_SRV0: w = '{uop: UOP_SERVE,  jc: JC_FAULT,    target: STEP_EMIT};
      STEP_SRV1: w = '{uop: UOP_SUMS,   jc: JC_GOTO,     target: STEP_EMIT};
      STEP_EMIT: w = '{uop: UOP_EMIT,   jc: JC_OUT_FREE, target: STEP_IDLE};
      default:   w = '{uop: UOP_NOP,    jc: JC_GOTO,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/psq_job_store.sv
// sorted job store: a row of cells that insert in place or shift toward the head
// depends on psq_pkg
`timescale 1ns / 1ps

module psq_job_store import psq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  store_cmd_t  cmd,
  input  job_t        new_job,
  output job_t        head_job,
  output store_stat_t stat
);

  job_t             q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;
  logic [CNT_W-1:0] cnt_r;
  logic             full;
  logic             empty;
  logic             do_ins;
  logic             do_srv;

  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_ins = cmd.insert && !full;
  assign do_srv = cmd.serve && !empty;

  // a cell holds its job when it is occupied and outranks or ties the new one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < cnt_r) && (q[i].prio >= new_job.prio);
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    job_t cell_r;
    job_t prev_job;
    job_t next_job;
    logic take_new;

    if (g == 0) begin : g_first
      assign take_new = 1'b1;
      assign prev_job = new_job;
    end else begin : g_rest
      assign take_new = keep[g-1];
      assign prev_job = q[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_job = cell_r;
    end else begin : g_mid
      assign next_job = q[g+1];
    end

    always_ff @(posedge clk) begin
      if (do_ins && !keep[g]) begin
        cell_r <= take_new ? new_job : prev_job;
      end else if (do_srv) begin
        cell_r <= next_job;
      end
    end

    assign q[g] = cell_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (do_ins) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (do_srv) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign head_job   = q[0];
  assign stat.full  = full;
  assign stat.empty = empty;
  assign stat.count = cnt_r;

endmodule

FILE: sv/priority_scheduler_queue.sv
// priority scheduler queue top: microcoded sequencer, timing arithmetic, result register
// depends on psq_pkg and psq_job_store
// a word is accepted only at the idle step, so a new word waits until the last one has run
// through the rom program (latch, insert or serve and sums, emit) and its result is loaded;
// a stalled result in the result register holds the emit step and so the next word
// reset: synchronous active-low rst_n empties the queue, zeroes time and sums
`timescale 1ns / 1ps

module priority_scheduler_queue import psq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // saturating 32-bit add
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  // sequencer
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ctl_t              ctl;
  logic              in_accept;
  logic              out_free;

  // datapath registers
  in_word_t    in_r;
  status_t     status_r;
  logic [15:0] sid_r;
  logic [7:0]  sprio_r;
  logic [31:0] wait_r;
  logic [31:0] tat_r;
  logic [31:0] time_r;
  logic [31:0] time_nxt;
  logic [31:0] sumw_r;
  logic [31:0] sumt_r;
  out_word_t   out_word_r;
  logic        out_valid_r;

  // store interface
  store_cmd_t  cmd;
  store_stat_t st;
  job_t        new_job;
  job_t        head_job;

  // the control word of the current step drives everything below
  assign ctl = ucode_rom(step_r);

  // input taken only at the idle step; a waiting result does not block it
  assign in_stall  = (step_r != STEP_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // next step: conditional jumps from the control word
  always_comb begin
    unique case (ctl.jc)
      JC_NEXT:     step_nxt = step_r + 1'b1;
      JC_GOTO:     step_nxt = ctl.target;
      // insert goes to target, serve to the step right after it
      JC_DISPATCH: step_nxt = in_accept ? ctl.target + STEP_W'(in_word.func) : step_r;
      // empty queue on serve: skip the sums straight to emit
      JC_FAULT:    step_nxt = st.empty ? ctl.target : step_r + 1'b1;
      JC_OUT_FREE: step_nxt = out_free ? ctl.target : step_r;
      default:     step_nxt = STEP_IDLE;
    endcase
  end

  // store commands
  assign cmd.insert = (ctl.uop == UOP_INSERT);
  assign cmd.serve  = (ctl.uop == UOP_SERVE);

  assign new_job.id    = in_r.process_id;
  assign new_job.burst = in_r.burst_length;
  assign new_job.prio  = in_r.job_priority;

  psq_job_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .new_job  (new_job),
    .head_job (head_job),
    .stat     (st)
  );

  // finishing time of the head job, which is also its turnaround
  assign time_nxt = sat_add32(time_r, {16'b0, head_job.burst});

  // control state and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      out_valid_r <= 1'b0;
      time_r      <= '0;
      sumw_r      <= '0;
      sumt_r      <= '0;
    end else begin
      step_r <= step_nxt;
      if (ctl.uop == UOP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.uop == UOP_SERVE && !st.empty) begin
        time_r <= time_nxt;
      end
      // both sums from registered operands, independent adds
      if (ctl.uop == UOP_SUMS) begin
        sumw_r <= sat_add32(sumw_r, wait_r);
        sumt_r <= sat_add32(sumt_r, tat_r);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.uop == UOP_LATCH && in_accept) begin
      in_r    <= in_word;
      sid_r   <= '0;
      sprio_r <= '0;
      wait_r  <= '0;
      tat_r   <= '0;
    end
    if (ctl.uop == UOP_INSERT) begin
      status_r <= st.full ? ST_DROPPED : ST_INSERTED;
    end
    if (ctl.uop == UOP_SERVE) begin
      if (st.empty) begin
        status_r <= ST_EMPTY;
      end else begin
        status_r <= ST_SERVED;
        sid_r    <= head_job.id;
        sprio_r  <= head_job.prio;
        wait_r   <= time_r;
        tat_r    <= time_nxt;
      end
    end
    // result register: holds while stalled, loaded only when free
    if (ctl.uop == UOP_EMIT && out_free) begin
      out_word_r.status           <= status_r;
      out_word_r.served_id        <= sid_r;
      out_word_r.served_priority  <= sprio_r;
      out_word_r.waiting_time     <= wait_r;
      out_word_r.turnaround_time  <= tat_r;
      out_word_r.total_waiting    <= sumw_r;
      out_word_r.total_turnaround <= sumt_r;
      out_word_r.queue_count      <= 5'(st.count);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: sv/psq_checker.sv
// port-level checker for the priority scheduler queue, bound to the top level
// depends on psq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psq_props import psq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  logic served_w;
  logic dropped_w;
  logic empty_w;
  logic empty_clean;
  logic tat_ok;

  assign served_w    = out_valid && (out_word.status == ST_SERVED);
  assign dropped_w   = out_valid && (out_word.status == ST_DROPPED);
  assign empty_w     = out_valid && (out_word.status == ST_EMPTY);
  assign empty_clean = (out_word.queue_count == '0) && (out_word.served_id == '0)
                       && (out_word.waiting_time == '0);
  assign tat_ok      = (out_word.turnaround_time >= out_word.waiting_time)
                       && (out_word.total_turnaround >= out_word.total_waiting);

  // a stalled result word stays put
  `PSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

  // a taken word keeps the input busy for the next cycle
  `PSQ_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall)

  // a dropped job means the queue was full
  `PSQ_ASSERT(a_drop_full, clk, rst_n, !dropped_w || (out_word.queue_count == 5'(QUEUE_DEPTH)))

  // empty serve reports nothing served
  `PSQ_ASSERT(a_empty_serve, clk, rst_n, !empty_w || empty_clean)

  // turnaround never below waiting, per job and in the sums
  `PSQ_ASSERT(a_tat_order, clk, rst_n, !served_w || tat_ok)

endmodule

bind priority_scheduler_queue psq_props u_psq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
